// ----- hw/rtl/nosl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes of the nearest-obstacle speed limiter.
// No dependencies; the top level, front end, queue, divider, back end and testbench import this package.
package nosl_pkg;

  localparam int COORD_BITS = 16;
  localparam int RATIO_BITS = 16;

  // coordinate bits taken from each 16-bit field
  localparam int CB    = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int SQ_W  = 2 * CB;
  localparam int SUM_W = (SQ_W + 2 > 33) ? SQ_W + 2 : 33;

  localparam logic [31:0]           MIN_ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0]           NEAR_LIMIT_SQ = 32'd100;
  localparam logic [RATIO_BITS-1:0] RATIO_ONE     = '1;

  // restoring divider of the back end
  localparam int DIV_DW    = (RATIO_BITS > 16) ? RATIO_BITS : 16;
  localparam int DIV_QB    = (RATIO_BITS > 16) ? RATIO_BITS : 16;
  localparam int DIV_NW    = DIV_DW + DIV_QB;
  localparam int DIV_CNT_W = $clog2(DIV_QB + 1);

  localparam int PROD_W = RATIO_BITS + 15;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // configuration register indexes
  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  CFG_RANGE_LOW  = 2'd0;
  localparam logic [1:0]  CFG_RANGE_HIGH = 2'd1;
  localparam logic [1:0]  CFG_SPEED_LIM  = 2'd2;

  localparam logic [15:0] RST_RANGE_LOW  = 16'd0;
  localparam logic [15:0] RST_RANGE_HIGH = 16'd1000;
  localparam logic [14:0] RST_SPEED_LIM  = 15'd2000;

  typedef enum logic {
    KIND_SPEED = 1'b0,
    KIND_LAST  = 1'b1
  } q_kind_e;

  typedef struct packed {
    q_kind_e     kind;
    logic [31:0] data;
  } q_entry_t;

  typedef struct packed {
    logic [15:0] range_low;
    logic [15:0] range_high;
    logic [14:0] speed_limit;
  } cfg_t;

endpackage

// ----- hw/rtl/nosl_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the speed limiter input and result.
// Stand-alone; no package needed.
interface nosl_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic               first_point;
  logic               last_point;
  logic signed [15:0] speed_in;

  modport source (output valid, command, point_x, point_y, point_z, first_point,
                  last_point, speed_in, input ready);
  modport sink   (input valid, command, point_x, point_y, point_z, first_point,
                  last_point, speed_in, output ready);
endinterface

interface nosl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_out;
  logic        [15:0] nearest_range;
  logic        [15:0] speed_ratio;

  modport source (output valid, speed_out, nearest_range, speed_ratio, input ready);
  modport sink   (input valid, speed_out, nearest_range, speed_ratio, output ready);
endinterface

// ----- hw/rtl/nearest_obstacle_speed_limiter.sv -----
`timescale 1ns / 1ps
// Nearest-obstacle speed limiter, top level with configuration registers.
// Depends on nosl_pkg, nosl_if, nosl_front, nosl_fifo and nosl_back.
//
// Cloud points and speed requests are taken one per cycle by the front end
// while it is not stalled by a full queue; it squares the coordinates in one
// stage and updates the running minimum in the next. Speed requests and
// end-of-cloud markers go through a four-entry queue to the back end. For a
// last point the back end pops it, runs the square-root unit, picks the ratio
// path, runs the bit-serial divider for the ratio (skipped when the ratio
// clamps to zero or one), multiplies by the speed limit, folds the product
// down by the full-scale ratio with shifts and adds (both skipped when the
// held speed is not positive), and loads the result; a speed request it only
// pops and stores. While the back end works, plain points keep flowing in; a
// speed or end-of-cloud entry waits in the front end while the queue is full.
// The result waits in an output register until taken. Configuration writes
// belong to idle periods.
module nearest_obstacle_speed_limiter import nosl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  nosl_in_if.sink              in_i,
  nosl_out_if.source           out_o
);

  cfg_t     cfg_q;
  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_in, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low   <= RST_RANGE_LOW;
      cfg_q.range_high  <= RST_RANGE_HIGH;
      cfg_q.speed_limit <= RST_SPEED_LIM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_LOW:  cfg_q.range_low   <= cfg_data_i;
        CFG_RANGE_HIGH: cfg_q.range_high  <= cfg_data_i;
        CFG_SPEED_LIM:  cfg_q.speed_limit <= cfg_data_i[14:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  nosl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (q_push),
    .push_entry_o (q_in),
    .full_i       (q_full)
  );

  nosl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  nosl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .head_i  (q_head),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue pushed while full");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("queue popped while empty");

  a_pop_only_idle_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_head.kind == KIND_LAST) |=> !q_pop)
    else $error("back end popped again while starting a cloud result");

endmodule

// ----- hw/rtl/nosl_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts requests, squares coordinates, tracks the minimum range.
// Depends on nosl_pkg and nosl_in_if; pushes speed and end-of-cloud entries.
module nosl_front import nosl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  nosl_in_if.sink  in_i,
  output logic     push_o,
  output q_entry_t push_entry_o,
  input  logic     full_i
);

  function automatic logic [CB-1:0] mag_of(logic [15:0] c);
    logic signed [CB:0] v;
    v = signed'({c[CB-1], c[CB-1:0]});
    if (v < 0) begin
      v = -v;
    end
    return v[CB-1:0];
  endfunction

  logic              st_valid_q;
  logic              st_cmd_q, st_first_q, st_last_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
  logic [15:0]       speed_q;
  logic [31:0]       min_q, min_d;

  logic [SUM_W-1:0]  sum;
  logic [31:0]       sq_sat, base_min;
  logic              need_push, st_go, accept;
  logic [CB-1:0]     mx, my, mz;

  assign mx = mag_of(in_i.point_x);
  assign my = mag_of(in_i.point_y);
  assign mz = mag_of(in_i.point_z);

  always_comb begin
    sum      = SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);
    sq_sat   = (sum > SUM_W'(MIN_ALL_ONES)) ? MIN_ALL_ONES : sum[31:0];
    // first point restarts the minimum before anything else
    base_min = st_first_q ? MIN_ALL_ONES : min_q;
    min_d    = base_min;
    if (!st_first_q && !st_last_q && (sq_sat > NEAR_LIMIT_SQ) && (sq_sat < base_min)) begin
      min_d = sq_sat;
    end
    need_push = st_cmd_q || st_last_q;
    st_go     = st_valid_q && (!need_push || !full_i);
    push_o    = st_go && need_push;
    push_entry_o.kind = st_cmd_q ? KIND_SPEED : KIND_LAST;
    push_entry_o.data = st_cmd_q ? {{16{speed_q[15]}}, speed_q} : base_min;
    in_i.ready = !st_valid_q || st_go;
  end

  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
      min_q      <= MIN_ALL_ONES;
    end else begin
      if (accept) begin
        st_valid_q <= 1'b1;
      end else if (st_go) begin
        st_valid_q <= 1'b0;
      end
      if (st_go && !st_cmd_q) begin
        min_q <= min_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_cmd_q   <= in_i.command;
      st_first_q <= in_i.first_point;
      st_last_q  <= in_i.last_point;
      sqx_q      <= SQ_W'(mx) * SQ_W'(mx);
      sqy_q      <= SQ_W'(my) * SQ_W'(my);
      sqz_q      <= SQ_W'(mz) * SQ_W'(mz);
      speed_q    <= in_i.speed_in;
    end
  end

endmodule

// ----- hw/rtl/nosl_fifo.sv -----
`timescale 1ns / 1ps
// Short flip-flop queue between the front end and the back end.
// Depends on nosl_pkg for the entry type and depth.
module nosl_fifo import nosl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  input  logic     pop_i,
  output q_entry_t head_o,
  output logic     full_o,
  output logic     empty_o
);

  q_entry_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q;

  assign full_o  = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- hw/rtl/nosl_isqrt.sv -----
`timescale 1ns / 1ps
// Bit-pair integer square root of a 32-bit value, one root bit per cycle.
// Depends on nothing outside this file.
module nosl_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  logic        busy_q, done_q;
  logic [31:0] rem_q, root_q, bit_q;
  logic [32:0] trial;
  logic        take;

  assign trial  = {1'b0, root_q} + {1'b0, bit_q};
  assign take   = ({1'b0, rem_q} >= trial);
  assign done_o = done_q;
  assign root_o = root_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (bit_q == 32'd1);
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (bit_q == 32'd1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= value_i;
      root_q <= '0;
      bit_q  <= 32'h4000_0000;
    end else if (busy_q) begin
      if (take) begin
        rem_q  <= rem_q - trial[31:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

// ----- hw/rtl/nosl_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, used by the back end for the
// ratio. Depends on nosl_pkg; the numerator must stay below den * 2^DIV_QB.
module nosl_div import nosl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              done_o,
  output logic [DIV_QB-1:0] quot_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DW-1:0]    rem_q, den_q;
  logic [DIV_QB-1:0]    low_q, quot_q;
  logic [DIV_DW:0]      t, diff;
  logic                 ge;

  assign t      = {rem_q, low_q[DIV_QB-1]};
  assign ge     = (t >= {1'b0, den_q});
  assign diff   = t - {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_QB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i[DIV_NW-1:DIV_QB];
      low_q  <= num_i[DIV_QB-1:0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DIV_DW-1:0] : t[DIV_DW-1:0];
      low_q  <= low_q << 1;
      quot_q <= {quot_q[DIV_QB-2:0], ge};
    end
  end

endmodule

// ----- hw/rtl/nosl_back.sv -----
`timescale 1ns / 1ps
// Back end: applies speed requests, and per cloud computes range, ratio and
// limited speed. Depends on nosl_pkg, nosl_out_if, nosl_isqrt and nosl_div.
module nosl_back import nosl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  q_entry_t  head_i,
  input  logic      empty_i,
  output logic      pop_o,
  nosl_out_if.source out_o
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_SQRT  = 3'd1;
  localparam logic [2:0] B_RSEL  = 3'd2;
  localparam logic [2:0] B_RDIV  = 3'd3;
  localparam logic [2:0] B_MUL   = 3'd4;
  localparam logic [2:0] B_SDIV  = 3'd5;
  localparam logic [2:0] B_DONE  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic signed [15:0]    stored_q, stored_d;
  logic [15:0]           d_q, d_d;
  logic [RATIO_BITS-1:0] ratio_q, ratio_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [14:0]           quot_q, quot_d;
  logic                  out_valid_q, out_valid_d;
  logic                  load_out;
  logic signed [15:0]    speed_out_q;
  logic [15:0]           range_out_q;
  logic [15:0]           ratio_out_q;

  logic                  sq_start, sq_done;
  logic [15:0]           sq_root;
  logic                  div_start, div_done;
  logic [DIV_NW-1:0]     div_num;
  logic [DIV_DW-1:0]     div_den;
  logic [DIV_QB-1:0]     div_quot;
  logic [15:0]           diff;
  logic [PROD_W-1:0]     fold_hi;

  nosl_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (head_i.data),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  nosl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign diff    = d_q - cfg_i.range_low;
  assign fold_hi = prod_q >> RATIO_BITS;

  always_comb begin
    state_d     = state_q;
    stored_d    = stored_q;
    d_d         = d_q;
    ratio_d     = ratio_q;
    prod_d      = prod_q;
    quot_d      = quot_q;
    pop_o       = 1'b0;
    sq_start    = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    // (d - low) * one as shift and subtract
    div_num     = (DIV_NW'(diff) << RATIO_BITS) - DIV_NW'(diff);
    div_den     = DIV_DW'(cfg_i.range_high - cfg_i.range_low);
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.kind == KIND_SPEED) begin
            stored_d = head_i.data[15:0];
          end else begin
            sq_start = 1'b1;
            state_d  = B_SQRT;
          end
        end
      end
      B_SQRT: begin
        if (sq_done) begin
          d_d     = sq_root;
          state_d = B_RSEL;
        end
      end
      B_RSEL: begin
        if (d_q <= cfg_i.range_low) begin
          ratio_d = '0;
          state_d = B_MUL;
        end else if ((cfg_i.range_high <= cfg_i.range_low) || (d_q >= cfg_i.range_high)) begin
          ratio_d = RATIO_ONE;
          state_d = B_MUL;
        end else begin
          div_start = 1'b1;
          state_d   = B_RDIV;
        end
      end
      B_RDIV: begin
        if (div_done) begin
          ratio_d = div_quot[RATIO_BITS-1:0];
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        if (stored_q > 16'sd0) begin
          prod_d  = PROD_W'(cfg_i.speed_limit) * PROD_W'(ratio_q);
          quot_d  = '0;
          state_d = B_SDIV;
        end else begin
          state_d = B_DONE;
        end
      end
      B_SDIV: begin
        // divide by the full-scale ratio: fold the high part onto the low part
        if (fold_hi != '0) begin
          quot_d = quot_q + fold_hi[14:0];
          prod_d = fold_hi + PROD_W'(prod_q[RATIO_BITS-1:0]);
        end else begin
          stored_d = {1'b0, quot_q + 15'(prod_q[RATIO_BITS-1:0] == RATIO_ONE)};
          state_d  = B_DONE;
        end
      end
      B_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || out_o.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      stored_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stored_q    <= stored_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    ratio_q <= ratio_d;
    prod_q  <= prod_d;
    quot_q  <= quot_d;
    if (load_out) begin
      speed_out_q <= stored_q;
      range_out_q <= d_q;
      ratio_out_q <= 16'(ratio_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.speed_out     = speed_out_q;
  assign out_o.nearest_range = range_out_q;
  assign out_o.speed_ratio   = ratio_out_q;

endmodule

// ----- tb/sv/tb_nearest_obstacle_speed_limiter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of nearest_obstacle_speed_limiter: drives speed requests and cloud
// points, predicts each limited speed, range and ratio, checks them on the result channel.
// Depends on nosl_pkg, nosl_if and the block's RTL.
module tb_nearest_obstacle_speed_limiter;
  import nosl_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic               command;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               opens_cloud;
    logic               closes_cloud;
    logic signed [15:0] speed;
  } cloud_req_t;

  typedef struct packed {
    logic signed [15:0] speed;
    logic        [15:0] range;
    logic        [15:0] ratio;
  } limit_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0]          cfg_data_i;

  nosl_in_if  req_if ();
  nosl_out_if res_if ();

  nearest_obstacle_speed_limiter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and register copies
  logic [31:0]        nearest_sq = '1;
  logic signed [15:0] held_speed = '0;
  logic [15:0]        low_mm     = RST_RANGE_LOW;
  logic [15:0]        high_mm    = RST_RANGE_HIGH;
  logic [14:0]        top_speed  = RST_SPEED_LIM;

  cloud_req_t point_stream[$];
  limit_t     pending_limits[$];
  cloud_req_t offered;

  int  fail_count    = 0;
  int  sent_count    = 0;
  int  checked_count = 0;
  int  setting_count = 1;
  int  cycle_count   = 0;
  int  send_gap      = 0;
  int  take_gap      = 0;
  logic idle_on    = 1'b1;
  logic hold_go    = 1'b0;
  logic stall_long = 1'b0;

  function automatic longint sq_of(logic signed [15:0] c);
    longint v;
    v = longint'(c);
    return v * v;
  endfunction

  function automatic logic [15:0] floor_root(logic [31:0] v);
    logic [15:0] root;
    logic [15:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      if (longint'(trial) * longint'(trial) <= longint'(v)) root = trial;
    end
    return root;
  endfunction

  function automatic logic [15:0] ratio_for(logic [15:0] d);
    if (d <= low_mm) return '0;
    if (high_mm <= low_mm || d >= high_mm) return 16'hFFFF;
    return 16'(((longint'(d) - longint'(low_mm)) * 65535)
               / (longint'(high_mm) - longint'(low_mm)));
  endfunction

  task automatic limit_speed(input cloud_req_t r);
    longint sq;
    limit_t res;
    if (r.command) begin
      held_speed = r.speed;
      return;
    end
    if (r.opens_cloud) nearest_sq = '1;
    if (!r.opens_cloud && !r.closes_cloud) begin
      sq = sq_of(r.x) + sq_of(r.y) + sq_of(r.z);
      if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
      if (sq > 100 && sq < longint'(nearest_sq)) nearest_sq = sq[31:0];
    end
    if (r.closes_cloud) begin
      res.range = floor_root(nearest_sq);
      res.ratio = ratio_for(res.range);
      if (held_speed > 0)
        held_speed = 16'((longint'(top_speed) * longint'(res.ratio)) / 65535);
      res.speed = held_speed;
      pending_limits.push_back(res);
    end
  endtask

  task automatic note_mismatch(input string what, input longint want, input longint got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        limit_speed(offered);
        sent_count++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap     <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (point_stream.size() > 0 && idle_on && $urandom_range(0, 9) == 0) begin
          send_gap     <= $urandom_range(0, 4);
          req_if.valid <= 1'b0;
        end else if (point_stream.size() > 0) begin
          offered = point_stream.pop_front();
          req_if.valid       <= 1'b1;
          req_if.command     <= offered.command;
          req_if.point_x     <= offered.x;
          req_if.point_y     <= offered.y;
          req_if.point_z     <= offered.z;
          req_if.first_point <= offered.opens_cloud;
          req_if.last_point  <= offered.closes_cloud;
          req_if.speed_in    <= offered.speed;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    limit_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      take_gap     <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_limits.size() == 0) begin
          note_mismatch("unrequested result, speed", longint'(0),
                        longint'(res_if.speed_out));
        end else begin
          want = pending_limits.pop_front();
          checked_count++;
          if (res_if.speed_out !== want.speed)
            note_mismatch("speed_out", longint'(want.speed), longint'(res_if.speed_out));
          if (res_if.nearest_range !== want.range)
            note_mismatch("nearest_range", longint'(want.range),
                          longint'(res_if.nearest_range));
          if (res_if.speed_ratio !== want.ratio)
            note_mismatch("speed_ratio", longint'(want.ratio),
                          longint'(res_if.speed_ratio));
        end
      end
      if (stall_long) begin
        res_if.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap     <= take_gap - 1;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        take_gap     <= $urandom_range(0, 4);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the end-of-cloud queue fills and backs up the input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    stall_long <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    stall_long <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[nearest_obstacle_speed_limiter] ERROR");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_coord(int span);
    case ($urandom_range(0, 15))
      0, 1:    return 16'($urandom_range(0, 65535));
      2:       return 16'(int'($urandom_range(0, 12)) - 6);
      default: return 16'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_speed();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 65535));
      1:       return '0;
      2:       return 16'(-int'($urandom_range(1, 32768)));
      default: return 16'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic cloud_req_t mk_point(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z, logic opens, logic closes);
    cloud_req_t r;
    r.command      = 1'b0;
    r.x            = x;
    r.y            = y;
    r.z            = z;
    r.opens_cloud  = opens;
    r.closes_cloud = closes;
    r.speed        = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic cloud_req_t mk_speed(logic signed [15:0] s);
    cloud_req_t r;
    r              = mk_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)), 1'($urandom), 1'($urandom));
    r.command      = 1'b1;
    r.speed        = s;
    return r;
  endfunction

  function automatic cloud_req_t rand_point(int span, logic opens, logic closes);
    return mk_point(pick_coord(span), pick_coord(span), pick_coord(span), opens, closes);
  endfunction

  // mostly well-formed clouds with random content, some speed requests, stray markers and points
  task automatic add_random(input int n, input int span, input int max_pts);
    int start;
    int pts;
    start = point_stream.size();
    while (point_stream.size() - start < n) begin
      case ($urandom_range(0, 19))
        0, 1: point_stream.push_back(mk_speed(pick_speed()));
        2:    point_stream.push_back(rand_point(span, 1'b0, 1'b0));
        3:    point_stream.push_back(rand_point(span, 1'($urandom), 1'($urandom)));
        default: begin
          point_stream.push_back(rand_point(span, 1'b1, $urandom_range(0, 11) == 0));
          pts = $urandom_range(0, max_pts);
          repeat (pts) begin
            if ($urandom_range(0, 11) == 0) point_stream.push_back(mk_speed(pick_speed()));
            else point_stream.push_back(rand_point(span, 1'b0, 1'b0));
          end
          point_stream.push_back(rand_point(span, 1'b0, 1'b1));
        end
      endcase
    end
  endtask

  task automatic wait_quiet();
    while (point_stream.size() != 0 || req_if.valid || pending_limits.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_RANGE_LOW:  low_mm    = val;
      CFG_RANGE_HIGH: high_mm   = val;
      CFG_SPEED_LIM:  top_speed = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] lim);
    write_reg(CFG_RANGE_LOW, lo);
    write_reg(CFG_RANGE_HIGH, hi);
    write_reg(CFG_SPEED_LIM, lim);
    setting_count++;
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_RANGE_LOW;
    cfg_data_i         = '0;
    req_if.valid       = 1'b0;
    req_if.command     = 1'b0;
    req_if.point_x     = '0;
    req_if.point_y     = '0;
    req_if.point_z     = '0;
    req_if.first_point = 1'b0;
    req_if.last_point  = 1'b0;
    req_if.speed_in    = '0;
    res_if.ready       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset limits, near radius boundary, extremes, flag combinations
    point_stream.push_back(mk_speed(16'sd1000));
    point_stream.push_back(mk_point(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0));
    point_stream.push_back(mk_point(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0));
    point_stream.push_back(mk_point(16'sd10, 16'sd0, 16'sd0, 1'b0, 1'b0));
    point_stream.push_back(mk_point(16'sd10, 16'sd1, 16'sd0, 1'b0, 1'b0));
    point_stream.push_back(mk_point(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1));
    point_stream.push_back(mk_point(16'sd3, 16'sd3, 16'sd3, 1'b0, 1'b1));
    point_stream.push_back(mk_point(16'sd1, 16'sd2, 16'sd3, 1'b1, 1'b1));
    point_stream.push_back(mk_speed(-16'sd32768));
    point_stream.push_back(mk_point(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0));
    point_stream.push_back(mk_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0));
    point_stream.push_back(mk_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 1'b0));
    point_stream.push_back(mk_point(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1));
    point_stream.push_back(mk_speed(16'sd32767));
    point_stream.push_back(mk_point(-16'sd1, -16'sd1, -16'sd1, 1'b1, 1'b0));
    point_stream.push_back(mk_point(16'sd300, -16'sd400, 16'sd0, 1'b0, 1'b0));
    point_stream.push_back(mk_point(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1));
    point_stream.push_back(mk_speed(16'sd0));
    point_stream.push_back(mk_point(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1));
    point_stream.push_back(mk_speed(16'sd500));
    point_stream.push_back(mk_point(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0));
    point_stream.push_back(mk_point(16'sd5, 16'sd5, -16'sd5, 1'b0, 1'b0));
    point_stream.push_back(mk_point(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1));
    point_stream.push_back(mk_speed(16'sd2500));
    point_stream.push_back(mk_point(16'sd1200, 16'sd0, 16'sd0, 1'b1, 1'b1));
    wait_quiet();

    add_random(180, 1500, 10);
    wait_quiet();

    set_limits(16'd200, 16'd3000, 16'd32767);
    add_random(180, 4000, 10);
    wait_quiet();

    // extremes: low above high, no speed at all, then the widest window
    set_limits(16'hFFFF, 16'd0, 16'd0);
    add_random(80, 32767, 8);
    wait_quiet();

    set_limits(16'd0, 16'hFFFF, 16'hFFFF);
    add_random(100, 32767, 8);
    wait_quiet();

    set_limits(16'd500, 16'd500, 16'd1234);
    add_random(80, 1000, 8);
    wait_quiet();

    // short clouds while the receiver holds off
    set_limits(16'd100, 16'd2000, 16'd5000);
    add_random(130, 2500, 2);
    hold_go = 1'b1;
    wait_quiet();

    set_limits(16'd50, 16'd800, 16'd3000);
    idle_on <= 1'b0;
    add_random(150, 1200, 10);
    wait_quiet();

    fail_count += pending_limits.size();
    $display("sent %0d requests, checked %0d limited speeds across %0d limit settings",
             sent_count, checked_count, setting_count);
    $display("mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("[nearest_obstacle_speed_limiter] OK");
    end else begin
      $display("[nearest_obstacle_speed_limiter] ERROR");
    end
    $finish;
  end

endmodule
